>>> design/utt_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared types and constants for the transcoder's front end, queue and back end.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [6:0]  ByteLimitReset    = 7'd60;

  // One input word.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_start;
    logic        string_end;
  } utt_in_t;

  // One output word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       terminator;
  } utt_out_t;

  // Byte sequence prepared by the front end for one input word. The bytes go
  // out in index order, followed by a terminator if term is set.
  typedef struct packed {
    logic [3:0][7:0] seq_bytes;
    logic [2:0]      nbytes;
    logic            term;
  } utt_job_t;

endpackage

>>> design/utt_front.sv
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts code units, tracks surrogate and string state, and queues the bytes.
// ----------------------------------------------------------------------------
module utt_front
  import utt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  utt_in_t    in_data_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output utt_job_t   q_data_o
);

  localparam logic [15:0] HighSurrFirst = 16'hD800;
  localparam logic [15:0] HighSurrLast  = 16'hDBFF;
  localparam logic [10:0] PlaneOffset   = 11'h040;  // 0x10000 >> 10
  localparam logic [6:0]  CountMax      = 7'h7F;

  logic [6:0] byte_limit_q;
  logic [9:0] pending_high_q, pending_high_d;
  logic       pending_valid_q, pending_valid_d;
  logic [6:0] byte_count_q, byte_count_d;
  logic       finished_q, finished_d;
  utt_job_t   job;
  logic       accept;

  assign in_ready_o  = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    logic [15:0] unit;
    logic [20:0] cp;
    logic [10:0] cp_hi;
    logic [7:0]  sum;
    logic        no_end_check;
    unit            = in_data_i.code_unit;
    cp_hi           = {1'b0, pending_high_q} + PlaneOffset;
    cp              = {cp_hi[10:0], unit[9:0]};
    sum             = '0;
    no_end_check    = 1'b0;
    job             = '0;
    pending_high_d  = pending_high_q;
    pending_valid_d = pending_valid_q;
    byte_count_d    = byte_count_q;
    finished_d      = finished_q;
    if (in_data_i.string_start) begin
      pending_high_d  = '0;
      pending_valid_d = 1'b0;
      byte_count_d    = '0;
      finished_d      = 1'b0;
    end
    if (!finished_d) begin
      // A held high surrogate always takes this word as its low half.
      if (pending_valid_d) begin
        job.seq_bytes[0] = {5'b11110, cp[20:18]};
        job.seq_bytes[1] = {2'b10, cp[17:12]};
        job.seq_bytes[2] = {2'b10, cp[11:6]};
        job.seq_bytes[3] = {2'b10, cp[5:0]};
        job.nbytes       = 3'd4;
        pending_valid_d  = 1'b0;
        pending_high_d   = '0;
      end else if (unit == '0) begin
        job.term     = 1'b1;
        finished_d   = 1'b1;
        no_end_check = 1'b1;
      end else if (unit >= HighSurrFirst && unit <= HighSurrLast) begin
        if (!in_data_i.string_end) begin
          pending_high_d  = unit[9:0];
          pending_valid_d = 1'b1;
          no_end_check    = 1'b1;
        end
      end else if (unit[15:7] == '0) begin
        job.seq_bytes[0] = unit[7:0];
        job.nbytes       = 3'd1;
      end else if (unit[15:11] == '0) begin
        job.seq_bytes[0] = {3'b110, unit[10:6]};
        job.seq_bytes[1] = {2'b10, unit[5:0]};
        job.nbytes       = 3'd2;
      end else begin
        job.seq_bytes[0] = {4'b1110, unit[15:12]};
        job.seq_bytes[1] = {2'b10, unit[11:6]};
        job.seq_bytes[2] = {2'b10, unit[5:0]};
        job.nbytes       = 3'd3;
      end
      if (!no_end_check) begin
        sum          = {1'b0, byte_count_d} + {5'b0, job.nbytes};
        byte_count_d = sum[7] ? CountMax : sum[6:0];
        if (in_data_i.string_end || byte_count_d >= byte_limit_q) begin
          job.term        = 1'b1;
          finished_d      = 1'b1;
          pending_valid_d = 1'b0;
          pending_high_d  = '0;
        end
      end
    end
  end

  assign q_push_o = accept && (job.term || job.nbytes != '0);
  assign q_data_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q    <= ByteLimitReset;
      pending_high_q  <= '0;
      pending_valid_q <= 1'b0;
      byte_count_q    <= '0;
      finished_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        byte_limit_q <= cfg_data_i;
      end
      if (accept) begin
        pending_high_q  <= pending_high_d;
        pending_valid_q <= pending_valid_d;
        byte_count_q    <= byte_count_d;
        finished_q      <= finished_d;
      end
    end
  end

  // Once the string is closed no surrogate can be held.
  a_no_pending_when_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pending_valid_q && finished_q))
    else $error("surrogate held after string end");

  // Every pushed sequence carries at least one byte.
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> (q_data_o.term || q_data_o.nbytes != '0))
    else $error("empty sequence queued");

  // A surrogate pair always gives exactly four bytes.
  a_pair_four_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pending_valid_q && !finished_q && !in_data_i.string_start)
      |-> (q_push_o && q_data_o.nbytes == 3'd4))
    else $error("surrogate pair not four bytes");

endmodule

>>> design/utt_queue.sv
// ----------------------------------------------------------------------------
// Transcoder sequence queue
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module utt_queue
  import utt_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  utt_job_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output utt_job_t head_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  utt_job_t        entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == FullCnt;
  assign empty_o = count_q == '0;
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count out of range");

endmodule

>>> design/utt_back.sv
// ----------------------------------------------------------------------------
// Transcoder back end
// Sends queued bytes via an output register, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module utt_back
  import utt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  utt_job_t head_i,
  input  logic     empty_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output utt_out_t out_data_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  utt_out_t   out_q, out_d;
  logic       emit, byte_is_term, is_last;

  assign emit         = (!out_valid_q || out_ready_i) && !empty_i;
  assign byte_is_term = idx_q == head_i.nbytes;
  assign is_last      = byte_is_term || (!head_i.term && idx_q == head_i.nbytes - 3'd1);
  assign pop_o        = emit && is_last;

  always_comb begin
    out_d.out_byte    = byte_is_term ? 8'h00 : head_i.seq_bytes[idx_q[1:0]];
    out_d.last_of_run = is_last;
    out_d.terminator  = byte_is_term;
    if (pop_o) begin
      idx_d = '0;
    end else if (emit) begin
      idx_d = idx_q + 3'd1;
    end else begin
      idx_d = idx_q;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_term_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.terminator) |-> (out_q.last_of_run && out_q.out_byte == 8'h00))
    else $error("terminator not a closing zero word");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q <= head_i.nbytes))
    else $error("byte index past sequence");

  a_idx_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == '0))
    else $error("byte index not cleared after sequence");

endmodule

>>> design/utf16_to_utf8_transcoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder unit
// Converts a stream of UTF-16 code units into UTF-8 bytes with string framing.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid_i, in_ready_o, in_data_i) takes one code
// unit per word with string start and end marks. The output channel
// (out_valid_o, out_ready_i, out_data_o) gives one UTF-8 byte per word, with
// last_of_run on the final byte caused by an input word and terminator on the
// closing zero byte of a string. The configuration channel (cfg_valid_i,
// cfg_ready_o, cfg_data_i) writes the byte limit; it is always ready and should
// only be used while the unit is idle.
// The bytes of an input word are written into the sequence queue and then
// pass through the output register. Throughput: the output register moves
// one byte per cycle while the receiver is ready; an input word causes from
// none to five bytes, a basic-plane character up to three plus a terminator.
// A new input word is taken every cycle while the sequence queue has room.
// Reset clears the surrogate, byte count and string state, empties the queue
// and sets the byte limit to 60. When the receiver stalls, the output word
// holds, the queue fills, and in_ready_o falls once it is full.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit
  import utt_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  utt_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output utt_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  logic     q_push, q_full, q_pop, q_empty;
  utt_job_t q_wdata, q_head;

  utt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  utt_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  utt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
